FILE: hdl/mf3_pkg.sv
// Shared types and constants for the 3x3 median filter.
// Holds the pixel type, configuration register codes and the median sorting network.
// No dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int PIX_W = 8;
    typedef logic [PIX_W-1:0] pix_t;

    // Window of nine pixels: columns c-2, c-1, c; top to bottom within each column
    localparam int WIN_N = 9;
    typedef pix_t [WIN_N-1:0] win_t;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 12;
    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 12'd480;

    // Smallest window edge: the frame must hold at least a 3x3 neighborhood
    localparam int MIN_EDGE = 3;

    // Median-of-nine compare/exchange network; the median ends at the middle slot
    localparam int NET_LEN = 19;
    localparam int MED_SLOT = WIN_N / 2;
    typedef logic [3:0] slot_t;
    localparam slot_t NET_A [NET_LEN] = '{
        4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
        4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
    };
    localparam slot_t NET_B [NET_LEN] = '{
        4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
        4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
    };

endpackage

FILE: hdl/median_filter_3x3_core.sv
// 3x3 median filter over raster-order 8-bit pixels; border pixels give no result.
// Pipeline: an accepted pixel is registered in the window stage, then its median is loaded into the output register.
// Throughput: one pixel per cycle, set by one line store read and one write per cycle.
// The input stalls only while a result is held in the output register with m_tready low.
// Reset: counters and window cleared, size set to 640x480; line stores are not cleared.
// Depends on mf3_pkg, mf3_line_buffer and mf3_median9.
`timescale 1ns / 1ps

module median_filter_3x3_core
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] median
    output logic                  m_tlast    // last result of the frame
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ?
                            $clog2(MAX_WIDTH + 1) : IMG_W_BITS;

    // Configuration registers
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;

    // Position counters
    logic [COL_W-1:0]      col_reg, col_next;
    logic [IMG_H_BITS-1:0] row_reg, row_next;

    // Window stage
    logic                  s1_valid_reg;
    pix_t                  s1_pixel_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    logic [COL_W-1:0]      s1_col_reg;
    pix_t                  win_reg [6];

    // Output register
    logic                  out_valid_reg;
    pix_t                  out_median_reg;
    logic                  out_last_reg;

    logic                  in_xfer;
    logic                  s1_adv;
    logic [WCMP_W-1:0]     w_ext, w_eff, w_last, col_ext;
    logic [IMG_H_BITS-1:0] h_eff;
    logic                  row_end, frame_end, emit;
    logic [2*PIX_W-1:0]    rd_data;
    pix_t                  up_pix, lo_pix;
    win_t                  win;
    pix_t                  median;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[IMG_H_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Handshake: stage advances unless its result is blocked by a full output
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_xfer  = s_tvalid && s_tready;

    // Clamp frame size
    always_comb
    begin
        w_ext = WCMP_W'(width_reg);
        if (w_ext < WCMP_W'(MIN_EDGE))
        begin
            w_eff = WCMP_W'(MIN_EDGE);
        end
        else if (w_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        w_last = w_eff - WCMP_W'(1);
        h_eff  = (height_reg < IMG_H_BITS'(MIN_EDGE)) ? IMG_H_BITS'(MIN_EDGE) : height_reg;
    end

    // Position of the arriving pixel
    always_comb
    begin
        col_ext   = WCMP_W'(col_reg);
        row_end   = col_ext >= w_last;
        frame_end = row_end && (row_reg >= h_eff - IMG_H_BITS'(1));
        emit      = (row_reg >= IMG_H_BITS'(2)) && (col_ext >= WCMP_W'(2));
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + IMG_H_BITS'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // Advance counters on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Window stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pixel_reg <= s_tdata[PIX_W-1:0];
            s1_emit_reg  <= emit;
            s1_last_reg  <= frame_end;
            s1_col_reg   <= col_reg;
        end
    end

    // Line stores: read at acceptance, rotate rows when the stage advances
    mf3_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_pixel_reg, lo_pix})
    );

    assign up_pix = rd_data[PIX_W-1:0];
    assign lo_pix = rd_data[2*PIX_W-1:PIX_W];

    // Shift window: drop oldest column, take current column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_pix;
            win_reg[4] <= lo_pix;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // Assemble the nine pixels
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win[i] = win_reg[i];
        end
        win[6] = up_pix;
        win[7] = lo_pix;
        win[8] = s1_pixel_reg;
    end

    mf3_median9 u_median9 (
        .win    (win),
        .median (median)
    );

    // Output register control: load on emitting advance, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_median_reg <= median;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_median_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/mf3_line_buffer.sv
// Two-row line store for the 3x3 median filter, kept as one 16-bit wide memory.
// Low byte holds row r-2, high byte row r-1. Registered read. Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_line_buffer
    import mf3_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [2*PIX_W-1:0]         rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*PIX_W-1:0]         wr_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    // Write one column of both rows
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one column of both rows
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/mf3_median9.sv
// Median of nine pixels through a fixed compare/exchange network.
// Purely combinational. Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_median9
    import mf3_pkg::*;
(
    input  win_t win,
    output pix_t median
);

    win_t v;

    // Run the network; each pair leaves the smaller value in slot A
    always_comb
    begin
        pix_t a;
        pix_t b;
        v = win;
        for (int i = 0; i < NET_LEN; i++)
        begin
            a = v[NET_A[i]];
            b = v[NET_B[i]];
            if (a > b)
            begin
                v[NET_A[i]] = b;
                v[NET_B[i]] = a;
            end
        end
    end

    assign median = v[MED_SLOT];

endmodule
